/* rtl/ors_pkg.sv */
package ors_pkg;

  localparam int RES_MAX = 3;
  localparam int FIFO_DEPTH = 8;

  localparam logic [7:0] ROM_REPORT_CAP = 8'd16;
  localparam logic [4:0] MAX_DEV_RESET = 5'd16;
  localparam logic [7:0] FAMILY_RESET = 8'h28;
  localparam logic [7:0] CMD_SEARCH = 8'hF0;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [6:0] ROM_BITS = 7'd64;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RESET_RESULT = 2'd1;
  localparam logic [1:0] OP_BIT_PAIR = 2'd2;

  localparam logic [2:0] KIND_WRITE_BIT = 3'd0;
  localparam logic [2:0] KIND_COMMAND = 3'd1;
  localparam logic [2:0] KIND_BUS_RESET = 3'd2;
  localparam logic [2:0] KIND_ROM_FOUND = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  localparam logic CFG_MAX_DEVICES = 1'b0;
  localparam logic CFG_FAMILY_FILTER = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESENCE,
    PH_WALK
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       presence;
    logic       id_bit;
    logic       cmp_bit;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        bit_value;
    logic [7:0]  command_byte;
    logic [63:0] rom_code;
    logic [4:0]  device_count;
    logic        status;
    logic        last;
  } res_t;

  typedef res_t [RES_MAX-1:0] res_vec_t;

  function automatic res_t mk_res(logic [2:0] kind, logic bit_value, logic [7:0] cmd,
                                  logic [63:0] rom, logic [4:0] count, logic status);
    res_t r;
    r.kind = kind;
    r.bit_value = bit_value;
    r.command_byte = cmd;
    r.rom_code = rom;
    r.device_count = count;
    r.status = status;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/onewire_rom_search_engine.sv */
// One-wire Search ROM engine driven by bus events: each input beat (start, reset result
// or id/complement bit pair) is registered, then handled combinationally by the walk logic,
// which queues up to three result beats (write bit, command byte, bus reset request,
// rom found, done) into an eight-entry result queue drained one beat per cycle while
// out_tready is high. An event is taken every cycle while the queue has room for the
// results of the events already in flight, so a steady stream of bit pairs runs at one beat
// per cycle; the end of a 64-bit pass yields up to three results and the queue absorbs them.
// An input beat's results pass the input register and the result queue. Configure only while idle.
module onewire_rom_search_engine #(
  parameter int FIFO_DEPTH = ors_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // presence, id_bit, cmp_bit, zero pad
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // bit_value, command_byte, rom_code, device_count, status, pad
  output logic [2:0]  out_tuser,  // kind
  output logic        out_tlast
);

  localparam int LW = $clog2(FIFO_DEPTH + 1);

  logic              in_valid_r;
  ors_pkg::item_t    item_r;
  ors_pkg::res_vec_t res;
  logic [1:0]        res_n;
  ors_pkg::res_t     head;
  logic [LW-1:0]     level;
  logic [LW:0]       need;
  logic              pop;

  assign need = {1'b0, level} + (in_valid_r ? (LW+1)'(ors_pkg::RES_MAX) : '0);
  assign in_tready = need <= (LW+1)'(FIFO_DEPTH - ors_pkg::RES_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.operation <= in_tuser;
      item_r.presence <= in_tdata[0];
      item_r.id_bit <= in_tdata[1];
      item_r.cmp_bit <= in_tdata[2];
    end
  end

  ors_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_valid(in_valid_r),
    .item      (item_r),
    .res_o     (res),
    .res_n_o   (res_n)
  );

  ors_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (res_n),
    .push_data(res),
    .pop      (pop),
    .head     (head),
    .level    (level)
  );

  assign out_tvalid = level != '0;
  assign pop = out_tvalid && out_tready;
  assign out_tuser = head.kind;
  assign out_tlast = head.last;
  assign out_tdata = {1'b0, head.status, head.device_count, head.rom_code,
                      head.command_byte, head.bit_value};

  // queue never overfills
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LW'(FIFO_DEPTH))
    else $error("result queue overflow");

  // done, command and bus reset always close the results of an event
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (head.kind == ors_pkg::KIND_DONE || head.kind == ors_pkg::KIND_COMMAND ||
                   head.kind == ors_pkg::KIND_BUS_RESET) |-> head.last)
    else $error("terminal result without last");

  // bus error status only with no device reported
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && head.status |-> head.kind == ors_pkg::KIND_DONE &&
                                  head.device_count == 5'd0)
    else $error("bad done status");

  // results are pushed into the queue only while an event is in flight
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    res_n != 2'd0 |-> in_valid_r)
    else $error("result without event");

endmodule

/* rtl/ors_walk.sv */
module ors_walk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              item_valid,
  input  ors_pkg::item_t    item,
  output ors_pkg::res_vec_t res_o,
  output logic [1:0]        res_n_o
);

  logic [4:0]      max_dev_r;
  logic [7:0]      family_r;
  ors_pkg::phase_t phase_r, phase_nxt;
  logic [63:0]     rom_r, rom_nxt;
  logic [6:0]      pos_r, pos_nxt;
  logic [6:0]      prior_r, prior_nxt;
  logic [6:0]      newb_r, newb_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic [4:0]      found_r, found_nxt;
  logic            final_r, final_nxt;

  logic [7:0]  lim;
  logic [5:0]  shift;
  logic        chosen;
  logic        mix;
  logic [1:0]  n;
  ors_pkg::res_vec_t res;

  assign lim = ({3'b000, max_dev_r} < ors_pkg::ROM_REPORT_CAP) ? {3'b000, max_dev_r}
                                                               : ors_pkg::ROM_REPORT_CAP;
  assign shift = 6'(pos_r - 7'd1);

  always_comb begin
    phase_nxt = phase_r;
    rom_nxt = rom_r;
    pos_nxt = pos_r;
    prior_nxt = prior_r;
    newb_nxt = newb_r;
    crc_nxt = crc_r;
    found_nxt = found_r;
    final_nxt = final_r;
    chosen = 1'b0;
    mix = 1'b0;
    n = 2'd0;
    res = '0;
    if (item_valid) begin
      if (item.operation == ors_pkg::OP_START) begin
        rom_nxt = '0;
        pos_nxt = 7'd1;
        prior_nxt = '0;
        newb_nxt = '0;
        crc_nxt = '0;
        found_nxt = '0;
        final_nxt = 1'b0;
        if (lim == 8'd0) begin
          phase_nxt = ors_pkg::PH_IDLE;
          res[0] = ors_pkg::mk_res(ors_pkg::KIND_DONE, 1'b0, 8'd0, 64'd0, 5'd0, 1'b0);
        end else begin
          phase_nxt = ors_pkg::PH_PRESENCE;
          res[0] = ors_pkg::mk_res(ors_pkg::KIND_BUS_RESET, 1'b0, 8'd0, 64'd0, 5'd0, 1'b0);
        end
        n = 2'd1;
      end else if (item.operation == ors_pkg::OP_RESET_RESULT &&
                   phase_r == ors_pkg::PH_PRESENCE) begin
        if (item.presence) begin
          phase_nxt = ors_pkg::PH_WALK;
          pos_nxt = 7'd1;
          newb_nxt = '0;
          crc_nxt = '0;
          res[0] = ors_pkg::mk_res(ors_pkg::KIND_COMMAND, 1'b0, ors_pkg::CMD_SEARCH,
                                   64'd0, 5'd0, 1'b0);
        end else begin
          phase_nxt = ors_pkg::PH_IDLE;
          res[0] = ors_pkg::mk_res(ors_pkg::KIND_DONE, 1'b0, 8'd0, 64'd0, found_r,
                                   found_r == 5'd0);
        end
        n = 2'd1;
      end else if (item.operation == ors_pkg::OP_BIT_PAIR &&
                   phase_r == ors_pkg::PH_WALK) begin
        if (item.id_bit && item.cmp_bit) begin
          phase_nxt = ors_pkg::PH_IDLE;
          res[0] = ors_pkg::mk_res(ors_pkg::KIND_DONE, 1'b0, 8'd0, 64'd0, found_r,
                                   found_r == 5'd0);
          n = 2'd1;
        end else begin
          if (item.id_bit != item.cmp_bit) begin
            chosen = item.id_bit;
          end else begin
            if (pos_r < prior_r) begin
              chosen = rom_r[shift];
            end else begin
              chosen = (pos_r == prior_r);
            end
            if (!chosen) begin
              newb_nxt = pos_r;
            end
          end
          rom_nxt[shift] = chosen;
          mix = crc_r[0] ^ chosen;
          crc_nxt = {1'b0, crc_r[7:1]} ^ (mix ? ors_pkg::CRC_POLY : 8'd0);
          res[0] = ors_pkg::mk_res(ors_pkg::KIND_WRITE_BIT, chosen, 8'd0, 64'd0, 5'd0, 1'b0);
          n = 2'd1;
          if (pos_r >= ors_pkg::ROM_BITS) begin
            prior_nxt = newb_nxt;
            final_nxt = (newb_nxt == 7'd0);
            pos_nxt = 7'd1;
            if (crc_nxt != 8'd0) begin
              phase_nxt = ors_pkg::PH_IDLE;
              res[1] = ors_pkg::mk_res(ors_pkg::KIND_DONE, 1'b0, 8'd0, 64'd0, found_r,
                                       found_r == 5'd0);
              n = 2'd2;
            end else begin
              if (rom_nxt[7:0] == family_r) begin
                res[n] = ors_pkg::mk_res(ors_pkg::KIND_ROM_FOUND, 1'b0, 8'd0, rom_nxt,
                                         5'd0, 1'b0);
                n = n + 2'd1;
                found_nxt = found_r + 5'd1;
              end
              if (final_nxt || ({3'b000, found_nxt} >= lim)) begin
                phase_nxt = ors_pkg::PH_IDLE;
                res[n] = ors_pkg::mk_res(ors_pkg::KIND_DONE, 1'b0, 8'd0, 64'd0, found_nxt,
                                         1'b0);
              end else begin
                phase_nxt = ors_pkg::PH_PRESENCE;
                res[n] = ors_pkg::mk_res(ors_pkg::KIND_BUS_RESET, 1'b0, 8'd0, 64'd0, 5'd0,
                                         1'b0);
              end
              n = n + 2'd1;
            end
          end else begin
            pos_nxt = pos_r + 7'd1;
          end
        end
      end
    end
    for (int i = 0; i < ors_pkg::RES_MAX; i++) begin
      res[i].last = ({30'd0, n} == i + 1);
    end
  end

  assign res_o = res;
  assign res_n_o = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dev_r <= ors_pkg::MAX_DEV_RESET;
      family_r <= ors_pkg::FAMILY_RESET;
      phase_r <= ors_pkg::PH_IDLE;
      rom_r <= '0;
      pos_r <= 7'd1;
      prior_r <= '0;
      newb_r <= '0;
      crc_r <= '0;
      found_r <= '0;
      final_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == ors_pkg::CFG_MAX_DEVICES) begin
        max_dev_r <= cfg_wdata[4:0];
      end
      if (cfg_we && cfg_index == ors_pkg::CFG_FAMILY_FILTER) begin
        family_r <= cfg_wdata;
      end
      phase_r <= phase_nxt;
      rom_r <= rom_nxt;
      pos_r <= pos_nxt;
      prior_r <= prior_nxt;
      newb_r <= newb_nxt;
      crc_r <= crc_nxt;
      found_r <= found_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

/* rtl/ors_fifo.sv */
module ors_fifo #(
  parameter int DEPTH = ors_pkg::FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 push_n,
  input  ors_pkg::res_vec_t          push_data,
  input  logic                       pop,
  output ors_pkg::res_t              head,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  ors_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [PW-1:0] wr_idx [ors_pkg::RES_MAX];

  function automatic logic [PW-1:0] ptr_add(logic [PW-1:0] p, logic [1:0] k);
    logic [PW+1:0] s;
    s = {2'b00, p} + {{PW{1'b0}}, k};
    if (s >= (PW+2)'(DEPTH)) begin
      s = s - (PW+2)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  always_comb begin
    for (int k = 0; k < ors_pkg::RES_MAX; k++) begin
      wr_idx[k] = ptr_add(wr_r, 2'(k));
    end
    wr_nxt = ptr_add(wr_r, push_n);
    rd_nxt = pop ? ptr_add(rd_r, 2'd1) : rd_r;
    level_nxt = level_r + LW'(push_n) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ors_pkg::RES_MAX; k++) begin
      if ({30'd0, push_n} > k) begin
        mem_r[wr_idx[k]] <= push_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      level_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      level_r <= level_nxt;
    end
  end

  assign head = mem_r[rd_r];
  assign level = level_r;

endmodule
